/* hdl/owtr_pkg.sv */
`timescale 1ns / 1ps

package owtr_pkg;

    // Sequencer phases, one-hot.
    typedef enum logic [12:0] {
        PH_IDLE = 13'b0_0000_0000_0001,
        PH_R1L  = 13'b0_0000_0000_0010,
        PH_R1W  = 13'b0_0000_0000_0100,
        PH_WL   = 13'b0_0000_0000_1000,
        PH_WR   = 13'b0_0000_0001_0000,
        PH_WG   = 13'b0_0000_0010_0000,
        PH_CONV = 13'b0_0000_0100_0000,
        PH_R2L  = 13'b0_0000_1000_0000,
        PH_R2W  = 13'b0_0001_0000_0000,
        PH_RL   = 13'b0_0010_0000_0000,
        PH_RS   = 13'b0_0100_0000_0000,
        PH_RR   = 13'b0_1000_0000_0000,
        PH_RG   = 13'b1_0000_0000_0000
    } t_phase;

    // Configuration register indexes.
    localparam logic [2:0] CFG_RESET_LOW      = 3'd0;
    localparam logic [2:0] CFG_PRESENCE       = 3'd1;
    localparam logic [2:0] CFG_WRITE_ONE_LOW  = 3'd2;
    localparam logic [2:0] CFG_WRITE_ZERO_LOW = 3'd3;
    localparam logic [2:0] CFG_WRITE_RECOVERY = 3'd4;
    localparam logic [2:0] CFG_READ_SAMPLE    = 3'd5;
    localparam logic [2:0] CFG_READ_RECOVERY  = 3'd6;
    localparam logic [2:0] CFG_CONV_WAIT      = 3'd7;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int TICK_W     = 20;

    // Register values after reset.
    localparam logic [11:0] DEF_RESET_LOW      = 12'd480;
    localparam logic [11:0] DEF_PRESENCE       = 12'd75;
    localparam logic [7:0]  DEF_WRITE_ONE_LOW  = 8'd6;
    localparam logic [7:0]  DEF_WRITE_ZERO_LOW = 8'd60;
    localparam logic [7:0]  DEF_WRITE_RECOVERY = 8'd69;
    localparam logic [7:0]  DEF_READ_SAMPLE    = 8'd20;
    localparam logic [7:0]  DEF_READ_RECOVERY  = 8'd45;
    localparam logic [19:0] DEF_CONV_WAIT      = 20'd750000;

    // Bus commands and protocol constants.
    localparam logic [7:0]  CMD_SKIP    = 8'hCC;
    localparam logic [7:0]  CMD_CONVERT = 8'h44;
    localparam logic [7:0]  CMD_READ    = 8'hBE;
    localparam logic [7:0]  CRC_POLY    = 8'h8C;
    localparam logic [19:0] GAP_TICKS   = 20'd105;
    localparam logic [3:0]  READ_BYTES  = 4'd9;
    localparam logic [3:0]  CRC_BYTES   = 4'd8;

    typedef struct packed {
        logic [11:0] reset_low;
        logic [11:0] presence;
        logic [7:0]  write_one_low;
        logic [7:0]  write_zero_low;
        logic [7:0]  write_recovery;
        logic [7:0]  read_sample;
        logic [7:0]  read_recovery;
        logic [19:0] conv_wait;
    } t_cfg;

    typedef struct packed {
        logic               drive_low;
        logic               busy_res;
        logic               done_res;
        logic               device_present;
        logic               crc_good;
        logic signed [15:0] temperature_raw;
        logic [7:0]         crc_computed;
        logic [7:0]         crc_received;
    } t_result;

    // Reflected CRC-8 of one byte, least significant bit first.
    function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        logic [7:0] d;
        logic       mix;
        crc = crc_in;
        d   = data;
        for (int i = 0; i < 8; i++) begin
            mix = crc[0] ^ d[0];
            crc = crc >> 1;
            if (mix) begin
                crc = crc ^ CRC_POLY;
            end
            d = d >> 1;
        end
        return crc;
    endfunction

endpackage

/* hdl/one_wire_temperature_reader.sv */
`timescale 1ns / 1ps

// One-wire temperature reader: a 1-Wire bus master with a CRC-8 check.
// Items arrive on the slave stream. tuser carries the action: 0 is a
// one-microsecond tick, 1 starts a reading (a start while busy is ignored).
// tdata bit 0 carries the sampled bus level. Each beat in produces exactly one
// result beat on the master stream; the result says whether to pull the line
// low for this tick, whether a reading is still running, whether this beat
// ended it, and the presence, CRC and temperature registers as they stand.
// Timing of the reset pulse, presence sample, write and read slots and the
// conversion wait come from eight registers on the plain write port; they are
// to be written only while the block is idle.
// Throughput is one item per clock cycle while the receiver keeps tready high.
// An item passes through an input register and then a single pass of
// sequencer logic into the output register, from which its result is
// offered on the master stream.
// When the receiver holds tready low, the output register keeps its result,
// the input register can take one more beat, and then tready on the slave
// side falls until the result is taken.
// Reset (synchronous, active low) returns the sequencer to idle, clears the
// result fields and loads the default timing registers.
module one_wire_temperature_reader (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] bus_level, [7:1] zero
    input  logic        s_axis_tuser,   // [0] action
    // Master stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [3] device_present,
    // [4] crc_good, [20:5] temperature_raw, [28:21] crc_computed,
    // [36:29] crc_received, [39:37] zero
    output logic [39:0] m_axis_tdata,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [19:0] i_cfg_wdata
);
    import owtr_pkg::*;

    t_cfg    cfg;
    t_result result;

    logic    r_in_valid;
    logic    r_in_action;
    logic    r_in_level;
    logic    r_out_valid;
    t_result r_out;

    logic    in_accept;
    logic    out_free;
    logic    fire;

    // The sequencer works on the held beat whenever the output register can
    // take its result.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    owtr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    owtr_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_action (r_in_action),
        .i_level  (r_in_level),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_action <= s_axis_tuser;
            r_in_level  <= s_axis_tdata[0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000,
                            r_out.crc_received,
                            r_out.crc_computed,
                            r_out.temperature_raw,
                            r_out.crc_good,
                            r_out.device_present,
                            r_out.done_res,
                            r_out.busy_res,
                            r_out.drive_low};

    // A finished reading never reports itself as still running.
    a_done_not_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.done_res && r_out.busy_res))
        else $error("result marks done while still busy");

    // A reading that found no device ends with empty data fields.
    a_absent_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res && !r_out.device_present) |->
        (r_out.temperature_raw == 16'sd0 && r_out.crc_computed == 8'd0
         && r_out.crc_received == 8'd0))
        else $error("absent device left data in the result");

    // Every processed beat lands in the output register.
    a_fire_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed beat produced no result");

    // Nothing is held in either register right after reset.
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_in_valid))
        else $error("pipeline not empty after reset");

endmodule

/* hdl/owtr_cfg.sv */
`timescale 1ns / 1ps

module owtr_cfg (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [owtr_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [owtr_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    output owtr_pkg::t_cfg                        o_cfg
);
    import owtr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low      <= DEF_RESET_LOW;
            r_cfg.presence       <= DEF_PRESENCE;
            r_cfg.write_one_low  <= DEF_WRITE_ONE_LOW;
            r_cfg.write_zero_low <= DEF_WRITE_ZERO_LOW;
            r_cfg.write_recovery <= DEF_WRITE_RECOVERY;
            r_cfg.read_sample    <= DEF_READ_SAMPLE;
            r_cfg.read_recovery  <= DEF_READ_RECOVERY;
            r_cfg.conv_wait      <= DEF_CONV_WAIT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_RESET_LOW:      r_cfg.reset_low      <= i_cfg_wdata[11:0];
                CFG_PRESENCE:       r_cfg.presence       <= i_cfg_wdata[11:0];
                CFG_WRITE_ONE_LOW:  r_cfg.write_one_low  <= i_cfg_wdata[7:0];
                CFG_WRITE_ZERO_LOW: r_cfg.write_zero_low <= i_cfg_wdata[7:0];
                CFG_WRITE_RECOVERY: r_cfg.write_recovery <= i_cfg_wdata[7:0];
                CFG_READ_SAMPLE:    r_cfg.read_sample    <= i_cfg_wdata[7:0];
                CFG_READ_RECOVERY:  r_cfg.read_recovery  <= i_cfg_wdata[7:0];
                CFG_CONV_WAIT:      r_cfg.conv_wait      <= i_cfg_wdata[19:0];
                default:            r_cfg.conv_wait      <= r_cfg.conv_wait;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/owtr_seq.sv */
`timescale 1ns / 1ps

module owtr_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_action,
    input  logic              i_level,
    input  owtr_pkg::t_cfg    i_cfg,
    output owtr_pkg::t_result o_result
);
    import owtr_pkg::*;

    t_phase             r_phase,    n_phase;
    logic [TICK_W-1:0]  r_tick,     n_tick;
    logic [2:0]         r_bit,      n_bit;
    logic [3:0]         r_byte,     n_byte;
    logic [7:0]         r_shift,    n_shift;
    logic [7:0]         r_crc,      n_crc;
    logic [15:0]        r_temp,     n_temp;
    logic [7:0]         r_rx_check, n_rx_check;
    logic               r_present,  n_present;
    logic               r_match,    n_match;

    logic [TICK_W-1:0]  len_raw;
    logic [TICK_W-1:0]  len;
    logic [TICK_W-1:0]  cnt;
    logic [2:0]         bit_next;
    logic [3:0]         byte_next;
    logic               drive;
    logic               done;

    // Line is pulled low in the reset pulses and in the low part of each slot.
    function automatic logic drives_low(input t_phase ph);
        return (ph == PH_R1L) || (ph == PH_R2L) || (ph == PH_WL) || (ph == PH_RL);
    endfunction

    always_comb begin
        case (r_phase)
            PH_R1L, PH_R2L: len_raw = {8'd0, i_cfg.reset_low};
            PH_R1W, PH_R2W: len_raw = {8'd0, i_cfg.presence};
            PH_WL:   len_raw = {12'd0, r_shift[0] ? i_cfg.write_one_low
                                                  : i_cfg.write_zero_low};
            PH_WR:   len_raw = {12'd0, i_cfg.write_recovery};
            PH_CONV: len_raw = i_cfg.conv_wait;
            PH_RS:   len_raw = {12'd0, i_cfg.read_sample};
            PH_RR:   len_raw = {12'd0, i_cfg.read_recovery};
            PH_WG, PH_RG: len_raw = GAP_TICKS;
            default: len_raw = TICK_W'(1);
        endcase
        // A zero-length phase still lasts one tick.
        len = (len_raw == '0) ? TICK_W'(1) : len_raw;
    end

    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_bit      = r_bit;
        n_byte     = r_byte;
        n_shift    = r_shift;
        n_crc      = r_crc;
        n_temp     = r_temp;
        n_rx_check = r_rx_check;
        n_present  = r_present;
        n_match    = r_match;
        done       = 1'b0;
        drive      = drives_low(r_phase);
        cnt        = r_tick + TICK_W'(1);
        bit_next   = r_bit + 3'd1;
        byte_next  = r_byte + 4'd1;

        if (i_action) begin
            if (r_phase == PH_IDLE) begin
                n_phase    = PH_R1L;
                n_tick     = '0;
                n_bit      = '0;
                n_byte     = '0;
                n_shift    = '0;
                n_crc      = '0;
                n_temp     = '0;
                n_rx_check = '0;
                n_present  = 1'b0;
                n_match    = 1'b0;
                drive      = 1'b1;
            end
        end else if (r_phase != PH_IDLE) begin
            if (cnt >= len) begin
                n_tick = '0;
                case (r_phase)
                    PH_R1L: n_phase = PH_R1W;
                    PH_R2L: n_phase = PH_R2W;
                    PH_R1W: begin
                        n_present = !i_level;
                        if (i_level) begin
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end else begin
                            n_byte  = 4'd0;
                            n_shift = CMD_SKIP;
                            n_bit   = 3'd0;
                            n_phase = PH_WL;
                        end
                    end
                    PH_R2W: begin
                        n_byte  = 4'd2;
                        n_shift = CMD_SKIP;
                        n_bit   = 3'd0;
                        n_phase = PH_WL;
                    end
                    PH_WL: n_phase = PH_WR;
                    PH_WR: begin
                        n_shift = r_shift >> 1;
                        n_bit   = bit_next;
                        n_phase = (bit_next == 3'd0) ? PH_WG : PH_WL;
                    end
                    PH_WG: begin
                        n_byte = byte_next;
                        if (byte_next == 4'd1) begin
                            n_shift = CMD_CONVERT;
                            n_bit   = 3'd0;
                            n_phase = PH_WL;
                        end else if (byte_next == 4'd2) begin
                            n_phase = PH_CONV;
                        end else if (byte_next == 4'd3) begin
                            n_shift = CMD_READ;
                            n_bit   = 3'd0;
                            n_phase = PH_WL;
                        end else begin
                            n_byte  = 4'd0;
                            n_bit   = 3'd0;
                            n_shift = 8'd0;
                            n_crc   = 8'd0;
                            n_phase = PH_RL;
                        end
                    end
                    PH_CONV: n_phase = PH_R2L;
                    PH_RL:   n_phase = PH_RS;
                    PH_RS: begin
                        n_shift = {i_level, r_shift[7:1]};
                        n_phase = PH_RR;
                    end
                    PH_RR: begin
                        n_bit = bit_next;
                        if (bit_next != 3'd0) begin
                            n_phase = PH_RL;
                        end else begin
                            if (r_byte < CRC_BYTES) begin
                                n_crc = crc_byte(r_crc, r_shift);
                            end
                            if (r_byte == 4'd0) begin
                                n_temp[7:0] = r_shift;
                            end else if (r_byte == 4'd1) begin
                                n_temp[15:8] = r_shift;
                            end else if (r_byte == CRC_BYTES) begin
                                n_rx_check = r_shift;
                                n_match    = (r_crc == r_shift);
                            end
                            n_phase = PH_RG;
                        end
                    end
                    PH_RG: begin
                        n_byte = byte_next;
                        if (byte_next >= READ_BYTES) begin
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end else begin
                            n_shift = 8'd0;
                            n_phase = PH_RL;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end else begin
                n_tick = cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_tick     <= '0;
            r_bit      <= '0;
            r_byte     <= '0;
            r_shift    <= '0;
            r_crc      <= '0;
            r_temp     <= '0;
            r_rx_check <= '0;
            r_present  <= 1'b0;
            r_match    <= 1'b0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_tick     <= n_tick;
            r_bit      <= n_bit;
            r_byte     <= n_byte;
            r_shift    <= n_shift;
            r_crc      <= n_crc;
            r_temp     <= n_temp;
            r_rx_check <= n_rx_check;
            r_present  <= n_present;
            r_match    <= n_match;
        end
    end

    always_comb begin
        o_result.drive_low       = drive;
        o_result.busy_res        = (n_phase != PH_IDLE);
        o_result.done_res        = done;
        o_result.device_present  = n_present;
        o_result.crc_good        = n_match;
        o_result.temperature_raw = n_temp;
        o_result.crc_computed    = n_crc;
        o_result.crc_received    = n_rx_check;
    end

endmodule

/* tb/one_wire_temperature_reader_tb.sv */
`timescale 1ns / 1ps

// Every beat sent into the reader yields exactly one result beat. A local model of
// the bus sequencer predicts each result when its beat is accepted. A second copy
// of that model runs ahead while stimulus is generated. It tells the generator
// which tick samples presence and which samples a read bit. This lets a device be
// emulated on the line, with presence and a random scratchpad.
module one_wire_temperature_reader_tb;
    import owtr_pkg::*;

    localparam int IDLE_PCT    = 32;
    localparam int STALL_LIMIT = 2000;
    // Slack waited after the last result is checked; allow some slack.
    localparam int SETTLE_CYCLES = 4;

    // State of the bus sequencer as seen from outside, at the block's own widths.
    typedef struct packed {
        t_phase      ph;
        logic [19:0] ticks;
        logic [2:0]  bit_no;
        logic [3:0]  byte_no;
        logic [7:0]  shreg;
        logic [7:0]  crc;
        logic [15:0] temp;
        logic [7:0]  crc_rx;
        logic        present;
        logic        crc_ok;
    } t_bus_seq;

    typedef struct packed {
        logic start;
        logic level;
    } t_bus_item;

    typedef enum logic [2:0] {
        PROFILE_DIRECTED,
        PROFILE_ZERO,
        PROFILE_FAST,
        PROFILE_MID
    } t_timing_profile;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_we      = 1'b0;
    logic [2:0]  i_cfg_addr    = 3'd0;
    logic [19:0] i_cfg_wdata   = 20'd0;

    // Timing registers as the block holds them, shared by both model copies.
    t_cfg        timing;
    logic [19:0] reg_raw [8];

    // sensor_now tracks accepted beats; sensor_plan runs ahead with the generator.
    t_bus_seq    sensor_now;
    t_bus_seq    sensor_plan;
    t_result     sensor_out;
    t_result     plan_out;
    t_result     oldest_due;
    t_bus_item   next_item;

    t_bus_item   bus_items_pending [$];
    t_result     sequencer_outputs_due [$];

    logic steady = 1'b0;
    int   failures       = 0;
    int   items_queued   = 0;
    int   items_accepted = 0;
    int   stall_cycles   = 0;

    always #5 i_clk = ~i_clk;

    one_wire_temperature_reader u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [0] bus_level, [7:1] zero
        .s_axis_tuser  (s_axis_tuser),   // [0] action
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [0] drive_low, [1] busy_res, [2] done_res, [3] device_present,
        // [4] crc_good, [20:5] temperature_raw, [28:21] crc_computed,
        // [36:29] crc_received
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------

    function automatic t_bus_seq cleared_seq(input t_phase p);
        t_bus_seq s;
        s.ph      = p;
        s.ticks   = '0;
        s.bit_no  = '0;
        s.byte_no = '0;
        s.shreg   = '0;
        s.crc     = '0;
        s.temp    = '0;
        s.crc_rx  = '0;
        s.present = 1'b0;
        s.crc_ok  = 1'b0;
        return s;
    endfunction

    // Reflected CRC-8, data taken least significant bit first.
    function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ b[k]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic line_low(input t_phase p);
        return p == PH_R1L || p == PH_R2L || p == PH_WL || p == PH_RL;
    endfunction

    // Ticks the current slot lasts; a register holding zero still gives one tick.
    function automatic logic [19:0] slot_length(input t_bus_seq s, input t_cfg c);
        logic [19:0] d;
        case (s.ph)
            PH_R1L, PH_R2L: d = 20'(c.reset_low);
            PH_R1W, PH_R2W: d = 20'(c.presence);
            PH_WL:          d = s.shreg[0] ? 20'(c.write_one_low) : 20'(c.write_zero_low);
            PH_WR:          d = 20'(c.write_recovery);
            PH_CONV:        d = c.conv_wait;
            PH_RS:          d = 20'(c.read_sample);
            PH_RR:          d = 20'(c.read_recovery);
            PH_WG, PH_RG:   d = GAP_TICKS;
            default:        d = 20'd1;
        endcase
        return (d == 20'd0) ? 20'd1 : d;
    endfunction

    function automatic void load_command(inout t_bus_seq s, input logic [7:0] cmd);
        s.shreg  = cmd;
        s.bit_no = '0;
        s.ph     = PH_WL;
    endfunction

    // Moves on once a slot has run its length; returns 1 when the reading ends.
    function automatic logic close_slot(inout t_bus_seq s, input logic level);
        logic finished;
        finished = 1'b0;
        case (s.ph)
            PH_R1L: s.ph = PH_R1W;
            PH_R2L: s.ph = PH_R2W;
            PH_R1W: begin
                s.present = (level == 1'b0);
                if (!s.present) begin
                    s.ph     = PH_IDLE;
                    finished = 1'b1;
                end else begin
                    s.byte_no = '0;
                    load_command(s, CMD_SKIP);
                end
            end
            PH_R2W: begin
                // Presence at the second reset is not looked at.
                s.byte_no = 4'd2;
                load_command(s, CMD_SKIP);
            end
            PH_WL: s.ph = PH_WR;
            PH_WR: begin
                s.shreg  = s.shreg >> 1;
                s.bit_no = s.bit_no + 3'd1;
                s.ph     = (s.bit_no == 3'd0) ? PH_WG : PH_WL;
            end
            PH_WG: begin
                // byte_no walks skip, convert, (wait), skip, read scratchpad.
                s.byte_no = s.byte_no + 4'd1;
                if (s.byte_no == 4'd1) begin
                    load_command(s, CMD_CONVERT);
                end else if (s.byte_no == 4'd2) begin
                    s.ph = PH_CONV;
                end else if (s.byte_no == 4'd3) begin
                    load_command(s, CMD_READ);
                end else begin
                    s.byte_no = '0;
                    s.bit_no  = '0;
                    s.shreg   = '0;
                    s.crc     = '0;
                    s.ph      = PH_RL;
                end
            end
            PH_CONV: s.ph = PH_R2L;
            PH_RL:   s.ph = PH_RS;
            PH_RS: begin
                s.shreg = {level, s.shreg[7:1]};
                s.ph    = PH_RR;
            end
            PH_RR: begin
                s.bit_no = s.bit_no + 3'd1;
                if (s.bit_no != 3'd0) begin
                    s.ph = PH_RL;
                end else begin
                    if (s.byte_no < CRC_BYTES) begin
                        s.crc = crc8_update(s.crc, s.shreg);
                    end
                    if (s.byte_no == 4'd0) begin
                        s.temp[7:0] = s.shreg;
                    end else if (s.byte_no == 4'd1) begin
                        s.temp[15:8] = s.shreg;
                    end else if (s.byte_no == CRC_BYTES) begin
                        s.crc_rx = s.shreg;
                        s.crc_ok = (s.crc == s.shreg);
                    end
                    s.ph = PH_RG;
                end
            end
            PH_RG: begin
                s.byte_no = s.byte_no + 4'd1;
                if (s.byte_no >= READ_BYTES) begin
                    s.ph     = PH_IDLE;
                    finished = 1'b1;
                end else begin
                    s.shreg = '0;
                    s.ph    = PH_RL;
                end
            end
            default: s.ph = PH_IDLE;
        endcase
        return finished;
    endfunction

    // One item through the sequencer: a start or a one-microsecond tick.
    function automatic t_result sensor_step(inout t_bus_seq s, input t_cfg c,
                                            input logic start, input logic level);
        t_result     r;
        logic        finished;
        logic [19:0] len;
        finished = 1'b0;
        if (start) begin
            // A start while busy changes nothing; the line level is that of the new phase.
            if (s.ph == PH_IDLE) begin
                s = cleared_seq(PH_R1L);
            end
            r.drive_low = line_low(s.ph);
        end else begin
            r.drive_low = line_low(s.ph);
            if (s.ph != PH_IDLE) begin
                len     = slot_length(s, c);
                s.ticks = s.ticks + 20'd1;
                if (s.ticks >= len) begin
                    s.ticks  = '0;
                    finished = close_slot(s, level);
                end
            end
        end
        r.busy_res        = (s.ph != PH_IDLE);
        r.done_res        = finished;
        r.device_present  = s.present;
        r.crc_good        = s.crc_ok;
        r.temperature_raw = s.temp;
        r.crc_computed    = s.crc;
        r.crc_received    = s.crc_rx;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: takes beats from the pending queue, idles at random, and records
    // the predicted result of each beat as it is accepted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                sensor_out = sensor_step(sensor_now, timing, s_axis_tuser, s_axis_tdata[0]);
                sequencer_outputs_due.push_back(sensor_out);
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (bus_items_pending.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_item = bus_items_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= next_item.start;
                    s_axis_tdata  <= {7'd0, next_item.level};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // The receiver stalls at random as well, except during the steady stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each result beat against the oldest prediction.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (sequencer_outputs_due.size() == 0) begin
                $error("result beat with no prediction outstanding");
                failures++;
            end else begin
                oldest_due = sequencer_outputs_due.pop_front();
                check_field("drive_low", oldest_due.drive_low, m_axis_tdata[0]);
                check_field("busy_res", oldest_due.busy_res, m_axis_tdata[1]);
                check_field("done_res", oldest_due.done_res, m_axis_tdata[2]);
                check_field("device_present", oldest_due.device_present, m_axis_tdata[3]);
                check_field("crc_good", oldest_due.crc_good, m_axis_tdata[4]);
                check_field("temperature_raw", int'(oldest_due.temperature_raw),
                            int'($signed(m_axis_tdata[20:5])));
                check_field("crc_computed", oldest_due.crc_computed, m_axis_tdata[28:21]);
                check_field("crc_received", oldest_due.crc_received, m_axis_tdata[36:29]);
            end
        end
    end

    // Watchdog: too many cycles without a beat on either side means a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("one_wire_temperature_reader_tb failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic post_item(input logic start, input logic level);
        t_bus_item it;
        it.start = start;
        it.level = level;
        bus_items_pending.push_back(it);
        plan_out = sensor_step(sensor_plan, timing, start, level);
        items_queued++;
    endtask

    // One whole reading with a device emulated on the line. The planning model
    // says which tick is a sampling tick. Presence and scratchpad bits go on those
    // ticks; every other tick gets a random level. A few starts while busy are
    // mixed in and must be ignored.
    task automatic run_reading(input logic present, input logic good_crc);
        logic [7:0]  pad [9];
        logic [19:0] len;
        logic        lvl;
        int          pick;
        for (int k = 0; k < 8; k++) begin
            pad[k] = 8'($urandom);
        end
        pick = $urandom_range(0, 5);
        if (pick == 0) begin
            pad[0] = 8'h00;
            pad[1] = 8'h80;
        end else if (pick == 1) begin
            pad[0] = 8'hFF;
            pad[1] = 8'h7F;
        end else if (pick == 2) begin
            pad[0] = 8'hFF;
            pad[1] = 8'hFF;
        end
        pad[8] = 8'h00;
        for (int k = 0; k < 8; k++) begin
            pad[8] = crc8_update(pad[8], pad[k]);
        end
        if (!good_crc) begin
            pad[8] = pad[8] ^ 8'($urandom_range(1, 255));
        end

        post_item(1'b1, 1'($urandom));
        while (sensor_plan.ph != PH_IDLE) begin
            if ($urandom_range(0, 99) < 3) begin
                post_item(1'b1, 1'($urandom));
            end else begin
                lvl = 1'($urandom);
                len = slot_length(sensor_plan, timing);
                if (sensor_plan.ticks + 20'd1 >= len) begin
                    if (sensor_plan.ph == PH_R1W) begin
                        lvl = !present;
                    end else if (sensor_plan.ph == PH_RS) begin
                        lvl = pad[sensor_plan.byte_no][sensor_plan.bit_no];
                    end
                end
                post_item(1'b0, lvl);
            end
        end
    endtask

    // Raw register words. Some carry junk above the register width, which the
    // block must drop.
    task automatic set_profile(input t_timing_profile p);
        case (p)
            PROFILE_DIRECTED: begin
                reg_raw[CFG_RESET_LOW]      = 20'hFF001;
                reg_raw[CFG_PRESENCE]       = 20'h00000;
                reg_raw[CFG_WRITE_ONE_LOW]  = 20'hABC01;
                reg_raw[CFG_WRITE_ZERO_LOW] = 20'h00002;
                reg_raw[CFG_WRITE_RECOVERY] = 20'h00001;
                reg_raw[CFG_READ_SAMPLE]    = 20'h00001;
                reg_raw[CFG_READ_RECOVERY]  = 20'h00000;
                reg_raw[CFG_CONV_WAIT]      = 20'h00001;
            end
            PROFILE_ZERO: begin
                for (int r = 0; r <= CFG_CONV_WAIT; r++) begin
                    reg_raw[r] = 20'd0;
                end
            end
            PROFILE_FAST: begin
                reg_raw[CFG_RESET_LOW]      = {8'($urandom), 12'($urandom_range(0, 3))};
                reg_raw[CFG_PRESENCE]       = {8'($urandom), 12'($urandom_range(0, 3))};
                reg_raw[CFG_WRITE_ONE_LOW]  = {12'($urandom), 8'($urandom_range(0, 3))};
                reg_raw[CFG_WRITE_ZERO_LOW] = {12'($urandom), 8'($urandom_range(0, 3))};
                reg_raw[CFG_WRITE_RECOVERY] = {12'($urandom), 8'($urandom_range(0, 3))};
                reg_raw[CFG_READ_SAMPLE]    = {12'($urandom), 8'($urandom_range(0, 3))};
                reg_raw[CFG_READ_RECOVERY]  = {12'($urandom), 8'($urandom_range(0, 3))};
                reg_raw[CFG_CONV_WAIT]      = 20'($urandom_range(0, 3));
            end
            default: begin
                reg_raw[CFG_RESET_LOW]      = 20'($urandom_range(1, 40));
                reg_raw[CFG_PRESENCE]       = 20'($urandom_range(1, 40));
                reg_raw[CFG_WRITE_ONE_LOW]  = 20'($urandom_range(1, 12));
                reg_raw[CFG_WRITE_ZERO_LOW] = 20'($urandom_range(1, 12));
                reg_raw[CFG_WRITE_RECOVERY] = 20'($urandom_range(1, 12));
                reg_raw[CFG_READ_SAMPLE]    = 20'($urandom_range(1, 12));
                reg_raw[CFG_READ_RECOVERY]  = 20'($urandom_range(1, 12));
                reg_raw[CFG_CONV_WAIT]      = 20'($urandom_range(1, 300));
            end
        endcase
    endtask

    // Writes all eight registers, one per cycle, and updates the model's copy.
    task automatic load_timing();
        for (int r = 0; r <= CFG_CONV_WAIT; r++) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= 3'(r);
            i_cfg_wdata <= reg_raw[r];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        timing.reset_low      = reg_raw[CFG_RESET_LOW][11:0];
        timing.presence       = reg_raw[CFG_PRESENCE][11:0];
        timing.write_one_low  = reg_raw[CFG_WRITE_ONE_LOW][7:0];
        timing.write_zero_low = reg_raw[CFG_WRITE_ZERO_LOW][7:0];
        timing.write_recovery = reg_raw[CFG_WRITE_RECOVERY][7:0];
        timing.read_sample    = reg_raw[CFG_READ_SAMPLE][7:0];
        timing.read_recovery  = reg_raw[CFG_READ_RECOVERY][7:0];
        timing.conv_wait      = reg_raw[CFG_CONV_WAIT];
    endtask

    // Waits until every queued beat has been taken and every result checked.
    task automatic drain();
        while (items_accepted != items_queued || sequencer_outputs_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        sensor_now  = cleared_seq(PH_IDLE);
        sensor_plan = cleared_seq(PH_IDLE);
        timing = '{reset_low: DEF_RESET_LOW, presence: DEF_PRESENCE,
                   write_one_low: DEF_WRITE_ONE_LOW, write_zero_low: DEF_WRITE_ZERO_LOW,
                   write_recovery: DEF_WRITE_RECOVERY, read_sample: DEF_READ_SAMPLE,
                   read_recovery: DEF_READ_RECOVERY, conv_wait: DEF_CONV_WAIT};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The directed items see one-tick reset and presence slots, so each step lands
        // where intended. The presence register holds zero and is treated as one tick.
        set_profile(PROFILE_DIRECTED);
        load_timing();
        post_item(1'b0, 1'b0);      // ticks while idle do nothing
        post_item(1'b0, 1'b1);
        post_item(1'b1, 1'b0);      // start: reset pulse pulls the line low
        post_item(1'b1, 1'b1);      // start while busy is ignored
        post_item(1'b0, 1'b0);      // reset pulse ends
        post_item(1'b0, 1'b1);      // nobody answers: the reading ends here
        post_item(1'b0, 1'b0);
        post_item(1'b1, 1'b1);
        post_item(1'b0, 1'b0);
        post_item(1'b1, 1'b0);      // start during the presence window
        post_item(1'b0, 1'b1);
        post_item(1'b1, 1'b0);      // back-to-back start right after a finish
        // A device answers this reading; the start that opens the emulated
        // reading lands while busy and is ignored.
        run_reading(1'b1, 1'b1);

        // Partway into the full reading, both sides stop idling for a long stretch.
        wait (items_accepted >= items_queued - 1100);
        steady = 1'b1;
        repeat (400) @(posedge i_clk);
        steady = 1'b0;
        drain();

        // Every slot at its shortest; an empty bus ends the reading at once.
        set_profile(PROFILE_ZERO);
        load_timing();
        run_reading(1'b0, 1'b0);
        drain();

        // Random timing on an empty bus, with idle ticks in between.
        repeat (3) begin
            set_profile($urandom_range(0, 1) ? PROFILE_MID : PROFILE_FAST);
            load_timing();
            repeat ($urandom_range(1, 2)) begin
                repeat ($urandom_range(0, 6)) post_item(1'b0, 1'($urandom));
                run_reading(1'b0, 1'b0);
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (failures == 0) begin
            $display("one_wire_temperature_reader_tb passed");
        end else begin
            $display("one_wire_temperature_reader_tb failed");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/owtr_pkg.sv
hdl/owtr_cfg.sv
hdl/owtr_seq.sv
hdl/one_wire_temperature_reader.sv
tb/one_wire_temperature_reader_tb.sv
